FILE: rtl/plane_wave_phase_grid_core_macros.svh
// Assertion macros shared by the checker of the plane-wave phase grid core.
// Depends on nothing; included by rtl/pwpg_checker.sv.
`ifndef PLANE_WAVE_PHASE_GRID_CORE_MACROS_SVH
`define PLANE_WAVE_PHASE_GRID_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle, checked outside reset.
`define PWPG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwpg: implication check failed");

// Antecedent implies consequent a fixed number of cycles later.
`define PWPG_ASSERT_AFTER(label, clk, rst_n, ante, lat, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(lat) (cons)) \
        else $error("pwpg: latency check failed");

`endif

FILE: rtl/pwpg_pkg.sv
// Package of the plane-wave phase grid core: widths, pipeline depths, register and quadrant
// codes, the CORDIC arctangent table and the structs passed between modules. Depends on nothing.
package pwpg_pkg;

    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;
    localparam int PHASE_W      = 32;
    localparam int OFFSET_W     = 10;
    localparam int OUT_W        = 18;
    localparam int CORDIC_W     = 27;
    localparam int CORDIC_ITERS = 24;
    localparam int PHASE_STAGES = 4;
    localparam int POST_STAGES  = 2;
    localparam int PIPE_LATENCY = PHASE_STAGES + CORDIC_ITERS + POST_STAGES;

    // Start vector of the rotation: full scale times the inverse CORDIC gain, times 2^8.
    localparam logic signed [CORDIC_W-1:0] X_INIT = 27'sd20375872;

    // Largest magnitude that a result may take; the code below it is never produced.
    localparam logic signed [OUT_W:0] OUT_LIMIT   = 19'sd131071;
    localparam logic [OUT_W-1:0]      OUT_ILLEGAL = 18'h20000;

    // atan(2^-i) as a fraction of one turn, scaled by 2^32.
    localparam logic signed [PHASE_W-1:0] ATAN_TABLE [CORDIC_ITERS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    // Register indexes in address order; the spare one has no register behind it.
    typedef enum logic [2:0] {
        REG_STEP_X       = 3'd0,
        REG_STEP_Y       = 3'd1,
        REG_STEP_Z       = 3'd2,
        REG_ORIGIN_PHASE = 3'd3,
        REG_START_X      = 3'd4,
        REG_START_Y      = 3'd5,
        REG_START_Z      = 3'd6,
        REG_SPARE        = 3'd7
    } reg_idx_t;

    // Quarter turn that the CORDIC vector is rotated by at the output.
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    typedef struct packed {
        logic [PHASE_W-1:0]  step_x;
        logic [PHASE_W-1:0]  step_y;
        logic [PHASE_W-1:0]  step_z;
        logic [PHASE_W-1:0]  origin_phase;
        logic [OFFSET_W-1:0] start_x;
        logic [OFFSET_W-1:0] start_y;
        logic [OFFSET_W-1:0] start_z;
    } cfg_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [PHASE_W-1:0]  z;
        logic [1:0]                 quad;
    } cordic_t;

endpackage

FILE: rtl/pwpg_regs.sv
// APB-style configuration register file of the plane-wave phase grid core.
// Depends on pwpg_pkg for the register widths, the register codes and the cfg_t struct.
module pwpg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pwpg_pkg::ADDR_W-1:0]   paddr,
    input  logic [pwpg_pkg::DATA_W-1:0]   pwdata,
    output logic [pwpg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output pwpg_pkg::cfg_t                cfg
);
    import pwpg_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_sel;
    logic       write_en;

    assign reg_sel  = paddr[ADDR_W-1:2];
    assign write_en = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (reg_sel)
                REG_STEP_X:       cfg_next.step_x       = pwdata;
                REG_STEP_Y:       cfg_next.step_y       = pwdata;
                REG_STEP_Z:       cfg_next.step_z       = pwdata;
                REG_ORIGIN_PHASE: cfg_next.origin_phase = pwdata;
                REG_START_X:      cfg_next.start_x      = pwdata[OFFSET_W-1:0];
                REG_START_Y:      cfg_next.start_y      = pwdata[OFFSET_W-1:0];
                REG_START_Z:      cfg_next.start_z      = pwdata[OFFSET_W-1:0];
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_STEP_X:       prdata = cfg_reg.step_x;
            REG_STEP_Y:       prdata = cfg_reg.step_y;
            REG_STEP_Z:       prdata = cfg_reg.step_z;
            REG_ORIGIN_PHASE: prdata = cfg_reg.origin_phase;
            REG_START_X:      prdata = DATA_W'(cfg_reg.start_x);
            REG_START_Y:      prdata = DATA_W'(cfg_reg.start_y);
            REG_START_Z:      prdata = DATA_W'(cfg_reg.start_z);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/pwpg_phase.sv
// Phase front end: global indices, per-axis products, phase sum and quadrant split.
// Depends on pwpg_pkg for widths and the cfg_t struct.
module pwpg_phase
#(
    parameter int INDEX_BITS = 10
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pwpg_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    input  logic [pwpg_pkg::OFFSET_W-1:0]       offset_x,
    input  logic [pwpg_pkg::OFFSET_W-1:0]       offset_y,
    input  logic [pwpg_pkg::OFFSET_W-1:0]       offset_z,
    output logic                                out_valid,
    output logic signed [pwpg_pkg::PHASE_W-1:0] out_z,
    output logic [1:0]                          out_quad
);
    import pwpg_pkg::*;

    // Only the low INDEX_BITS bits of start and offset count; the fields are 10 bits wide.
    localparam int IDX_USE = (INDEX_BITS < OFFSET_W) ? INDEX_BITS : OFFSET_W;
    localparam int IDX_W   = IDX_USE + 1;
    localparam int PROD_W  = PHASE_W + IDX_W;
    localparam logic [PHASE_W-1:0] QUAD_BIAS = 32'h2000_0000;

    logic [PHASE_STAGES-1:0] valid_reg;

    logic [IDX_W-1:0]   idx_x_reg, idx_y_reg, idx_z_reg;
    logic [IDX_W-1:0]   idx_x_next, idx_y_next, idx_z_next;
    logic [PROD_W-1:0]  prod_x_full, prod_y_full, prod_z_full;
    logic [PHASE_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W-1:0] phase_biased;
    logic [1:0]         quad_reg, quad_next;
    logic [PHASE_W-1:0] z_reg, z_next;

    assign idx_x_next = IDX_W'(cfg.start_x[IDX_USE-1:0]) + IDX_W'(offset_x[IDX_USE-1:0]);
    assign idx_y_next = IDX_W'(cfg.start_y[IDX_USE-1:0]) + IDX_W'(offset_y[IDX_USE-1:0]);
    assign idx_z_next = IDX_W'(cfg.start_z[IDX_USE-1:0]) + IDX_W'(offset_z[IDX_USE-1:0]);

    // Only the low 32 bits of each product matter, since the phase wraps at one turn.
    assign prod_x_full = cfg.step_x * idx_x_reg;
    assign prod_y_full = cfg.step_y * idx_y_reg;
    assign prod_z_full = cfg.step_z * idx_z_reg;

    assign phase_next   = prod_x_reg + prod_y_reg + prod_z_reg - cfg.origin_phase;
    assign phase_biased = phase_reg + QUAD_BIAS;
    assign quad_next    = phase_biased[PHASE_W-1:PHASE_W-2];
    assign z_next       = phase_reg - {quad_next, {(PHASE_W-2){1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[PHASE_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        idx_x_reg  <= idx_x_next;
        idx_y_reg  <= idx_y_next;
        idx_z_reg  <= idx_z_next;
        prod_x_reg <= prod_x_full[PHASE_W-1:0];
        prod_y_reg <= prod_y_full[PHASE_W-1:0];
        prod_z_reg <= prod_z_full[PHASE_W-1:0];
        phase_reg  <= phase_next;
        quad_reg   <= quad_next;
        z_reg      <= z_next;
    end

    assign out_valid = valid_reg[PHASE_STAGES-1];
    assign out_z     = $signed(z_reg);
    assign out_quad  = quad_reg;

endmodule

FILE: rtl/pwpg_cordic.sv
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
// Depends on pwpg_pkg for the arctangent table, start vector and cordic_t.
module pwpg_cordic
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [pwpg_pkg::PHASE_W-1:0] in_z,
    input  logic [1:0]                          in_quad,
    output logic                                out_valid,
    output pwpg_pkg::cordic_t                   out_data
);
    import pwpg_pkg::*;

    logic [CORDIC_ITERS-1:0] valid_reg;
    cordic_t                 stage_reg [CORDIC_ITERS];

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_iter
        cordic_t                    prev;
        cordic_t                    stage_next;
        logic                       prev_valid;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;

        if (i == 0)
        begin : g_seed
            assign prev.x     = X_INIT;
            assign prev.y     = '0;
            assign prev.z     = in_z;
            assign prev.quad  = in_quad;
            assign prev_valid = in_valid;
        end
        else
        begin : g_chain
            assign prev       = stage_reg[i-1];
            assign prev_valid = valid_reg[i-1];
        end

        assign dx = $signed(prev.y) >>> i;
        assign dy = $signed(prev.x) >>> i;

        // Rotate towards zero residual angle; the sign of z picks the direction.
        always_comb
        begin
            stage_next = prev;
            if (!prev.z[PHASE_W-1])
            begin
                stage_next.x = prev.x - dx;
                stage_next.y = prev.y + dy;
                stage_next.z = prev.z - ATAN_TABLE[i];
            end
            else
            begin
                stage_next.x = prev.x + dx;
                stage_next.y = prev.y - dy;
                stage_next.z = prev.z + ATAN_TABLE[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[i] <= stage_next;
        end
    end

    assign out_valid = valid_reg[CORDIC_ITERS-1];
    assign out_data  = stage_reg[CORDIC_ITERS-1];

endmodule

FILE: rtl/pwpg_post.sv
// Back end: rounding and clamping of the CORDIC vector, then quadrant rotation.
// Depends on pwpg_pkg for widths, the output limit, the quadrant codes and cordic_t.
module pwpg_post
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  pwpg_pkg::cordic_t                 in_data,
    output logic                              out_valid,
    output logic signed [pwpg_pkg::OUT_W-1:0] out_cos,
    output logic signed [pwpg_pkg::OUT_W-1:0] out_sin
);
    import pwpg_pkg::*;

    localparam logic signed [CORDIC_W-1:0] ROUND_HALF = 27'sd128;

    logic [POST_STAGES-1:0] valid_reg;

    logic signed [CORDIC_W-1:0] x_rnd, y_rnd;
    logic signed [OUT_W:0]      c_wide, s_wide;
    logic signed [OUT_W-1:0]    c_reg, c_next, s_reg, s_next;
    logic [1:0]                 quad_reg;
    logic signed [OUT_W-1:0]    cos_reg, cos_next, sin_reg, sin_next;

    // Adding half an LSB and dropping eight bits rounds to nearest.
    assign x_rnd  = in_data.x + ROUND_HALF;
    assign y_rnd  = in_data.y + ROUND_HALF;
    assign c_wide = x_rnd[CORDIC_W-1:8];
    assign s_wide = y_rnd[CORDIC_W-1:8];

    always_comb
    begin
        if (c_wide > OUT_LIMIT)
            c_next = OUT_LIMIT[OUT_W-1:0];
        else if (c_wide < -OUT_LIMIT)
            c_next = -OUT_LIMIT[OUT_W-1:0];
        else
            c_next = c_wide[OUT_W-1:0];

        if (s_wide > OUT_LIMIT)
            s_next = OUT_LIMIT[OUT_W-1:0];
        else if (s_wide < -OUT_LIMIT)
            s_next = -OUT_LIMIT[OUT_W-1:0];
        else
            s_next = s_wide[OUT_W-1:0];
    end

    always_comb
    begin
        case (quad_reg)
            QUAD_0:
            begin
                cos_next = c_reg;
                sin_next = s_reg;
            end
            QUAD_90:
            begin
                cos_next = -s_reg;
                sin_next = c_reg;
            end
            QUAD_180:
            begin
                cos_next = -c_reg;
                sin_next = -s_reg;
            end
            QUAD_270:
            begin
                cos_next = s_reg;
                sin_next = -c_reg;
            end
            default:
            begin
                cos_next = c_reg;
                sin_next = s_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[POST_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg    <= c_next;
        s_reg    <= s_next;
        quad_reg <= in_data.quad;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
    end

    assign out_valid = valid_reg[POST_STAGES-1];
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;

endmodule

FILE: rtl/plane_wave_phase_grid_core.sv
// Top level of the plane-wave phase grid core: register file, phase front end,
// CORDIC pipeline and output stage. Depends on pwpg_pkg and the pwpg_* modules.

// The core turns a grid point, given by its offsets within a box, into the
// plane-wave phase factor exp(i*k.r) as a cosine and sine pair in signed 18-bit
// fixed point scaled by 131071. Each offset is added to its axis start index,
// the sum is multiplied by that axis's phase step (a fraction of one turn scaled
// by 2^32), the three products are added, the origin phase is subtracted and the
// total wraps at one turn. An item is taken on every clock edge at which start is
// high; busy never rises, because the whole datapath is a fixed pipeline with no
// loop back. Each item comes out as a one-cycle pulse of result_valid with
// cos_value and sin_value, in the order the items went in, after registers for
// the index add, the three per-axis multiplies, the phase sum and the quadrant
// split, the CORDIC micro-rotations, one per stage, and the rounding, clamping
// and rotation into the right quadrant. The receiver cannot stall the output,
// so results must be captured on the cycle they are shown.
// Registers are written through the APB-style port at byte addresses 4*i:
// step_x, step_y, step_z, origin_phase, start_x, start_y, start_z; they should
// only be changed while no item is in flight, as items in the pipe read them.
// INDEX_BITS sets how many low bits of start and offset take part in the index.
module plane_wave_phase_grid_core
#(
    parameter int INDEX_BITS = 10
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pwpg_pkg::ADDR_W-1:0]         paddr,
    input  logic [pwpg_pkg::DATA_W-1:0]         pwdata,
    output logic [pwpg_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic [pwpg_pkg::OFFSET_W-1:0]       offset_x,
    input  logic [pwpg_pkg::OFFSET_W-1:0]       offset_y,
    input  logic [pwpg_pkg::OFFSET_W-1:0]       offset_z,
    output logic                                result_valid,
    output logic signed [pwpg_pkg::OUT_W-1:0]   cos_value,
    output logic signed [pwpg_pkg::OUT_W-1:0]   sin_value
);
    import pwpg_pkg::*;

    cfg_t                       cfg;
    logic                       accept;
    logic                       phase_valid;
    logic signed [PHASE_W-1:0]  phase_z;
    logic [1:0]                 phase_quad;
    logic                       cordic_valid;
    cordic_t                    cordic_data;

    // The pipeline advances every cycle, so an item is never refused.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    pwpg_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pwpg_phase
    #(
        .INDEX_BITS (INDEX_BITS)
    )
    u_phase
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (accept),
        .offset_x  (offset_x),
        .offset_y  (offset_y),
        .offset_z  (offset_z),
        .out_valid (phase_valid),
        .out_z     (phase_z),
        .out_quad  (phase_quad)
    );

    pwpg_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (phase_valid),
        .in_z      (phase_z),
        .in_quad   (phase_quad),
        .out_valid (cordic_valid),
        .out_data  (cordic_data)
    );

    pwpg_post u_post
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cordic_valid),
        .in_data   (cordic_data),
        .out_valid (result_valid),
        .out_cos   (cos_value),
        .out_sin   (sin_value)
    );

endmodule

FILE: rtl/pwpg_checker.sv
// Port-level checker of the plane-wave phase grid core, bound to the top level.
// Depends on pwpg_pkg and plane_wave_phase_grid_core_macros.svh.
`include "plane_wave_phase_grid_core_macros.svh"

module pwpg_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              result_valid,
    input logic signed [pwpg_pkg::OUT_W-1:0] cos_value,
    input logic signed [pwpg_pkg::OUT_W-1:0] sin_value
);
    import pwpg_pkg::*;

    // Every accepted item yields a result after the fixed pipeline latency.
    `PWPG_ASSERT_AFTER(a_item_yields_result, clk, rst_n, start && !busy, PIPE_LATENCY, result_valid)

    // No result appears without an item taken the fixed latency earlier.
    `PWPG_ASSERT_IMPLY(a_result_has_item, clk, rst_n, result_valid, $past(start && !busy, PIPE_LATENCY))

    // Clamping keeps both parts off the most negative code.
    `PWPG_ASSERT_IMPLY(a_cos_in_range, clk, rst_n, result_valid, cos_value != OUT_ILLEGAL)
    `PWPG_ASSERT_IMPLY(a_sin_in_range, clk, rst_n, result_valid, sin_value != OUT_ILLEGAL)

endmodule

bind plane_wave_phase_grid_core pwpg_checker u_pwpg_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .cos_value    (cos_value),
    .sin_value    (sin_value)
);
